FILE: rtl/core/sgrpm_pkg.sv
// Package for the stereo gain ramp and peak meter core.
// Holds the shared constants, register indexes and controller/datapath structs.
// No dependencies.
package sgrpm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 24;
	localparam int CFG_IDX_W = 2;

	// Unity in Q1.23.
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 24'h800000;

	localparam logic [LEVEL_W-1:0] GATE_STEP_RST     = 24'd38044;
	localparam logic [LEVEL_W-1:0] VOLUME_STEP_RST   = 24'd254;
	localparam logic [LEVEL_W-1:0] VOLUME_TARGET_RST = FULL_SCALE;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GATE_STEP     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEP   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_TARGET = 2'd2;

	// Commands from the controller to the datapath. At most one is active.
	typedef struct packed {
		logic load;   // take the input transaction and advance the ramps
		logic gain;   // form the gate times volume product
		logic mag;    // multiply both magnitudes by the gain
		logic lo;     // low partial product of the second multiplication
		logic hi;     // high partial product of the second multiplication
		logic fin;    // sum partials and load the output register
	} sgrpm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // output register can take a new result this cycle
	} sgrpm_stat_t;

endpackage

FILE: rtl/core/sgrpm_if.sv
// Channel interfaces of the stereo gain ramp and peak meter core.
// Depends on sgrpm_pkg for field widths.
interface sgrpm_in_if import sgrpm_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;
	logic                       fade_out;
	logic                       clear_peaks;

	modport source (output valid, left_in, right_in, fade_out, clear_peaks, input ready);
	modport sink (input valid, left_in, right_in, fade_out, clear_peaks, output ready);
endinterface

interface sgrpm_out_if import sgrpm_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic        [SAMPLE_W-1:0] peak_left;
	logic        [SAMPLE_W-1:0] peak_right;

	modport source (output valid, left_out, right_out, peak_left, peak_right, input ready);
	modport sink (input valid, left_out, right_out, peak_left, peak_right, output ready);
endinterface

interface sgrpm_cfg_if import sgrpm_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LEVEL_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/stereo_gain_ramp_peak_meter_core.sv
// Top level of the stereo gain ramp and peak meter core.
// Depends on sgrpm_pkg, the interfaces in sgrpm_if, sgrpm_ctrl and sgrpm_dp.
//
// Usage:
// The core takes one stereo sample pair per transaction on src, together with a
// fade_out flag that steers the soft mute gate and a clear_peaks flag. For every
// input transaction it returns exactly one output transaction on dst holding the
// two scaled samples and the held peak magnitude of each channel.
// The gain is (gate * volume) squared, all in unsigned Q1.23; the gate and the
// volume each take one ramp step per sample before the scaling.
// Sequencing: each accepted input goes through one gate-times-volume product and
// three passes through the per-channel multipliers, each result registered before
// the next pass, then a final step that loads the output register. A new input is
// taken only once the previous one has left its final step.
// Configuration writes on cfg are always accepted and are meant for idle times.
// Reset loads the default ramp steps, full-scale target and volume, a closed
// gate and zero peaks. When dst stalls, one finished result waits in the output
// register while the next input is accepted and processed; that one then waits
// in its final step until the output register is taken.
module stereo_gain_ramp_peak_meter_core
	import sgrpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sgrpm_in_if.sink    src,
	sgrpm_out_if.source dst,
	sgrpm_cfg_if.sink   cfg
);

	sgrpm_cmd_t  cmd;
	sgrpm_stat_t stat;
	logic        in_ready;

	// The controller only sequences; all arithmetic and data registers sit in the datapath.
	sgrpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (src.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign src.ready = in_ready;

	sgrpm_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src),
		.dst    (dst),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

`ifndef SYNTHESIS
	// Only one datapath step is commanded in any cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command active");

	// An accepted transaction reaches its final step after a fixed sequence.
	a_fixed_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> ##5 cmd.fin)
		else $error("final step not reached five cycles after accept");

	// A finished result moves into the output register when it has room.
	a_result_delivered: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && stat.out_free) |=> dst.valid)
		else $error("result not presented after final step");

	// Without room the final step is held rather than dropped.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin && !stat.out_free) |=> cmd.fin)
		else $error("final step left while output register full");
`endif

endmodule

FILE: rtl/core/sgrpm_ctrl.sv
// Sequencing controller of the stereo gain ramp and peak meter core.
// Depends on sgrpm_pkg for the command and status structs.
module sgrpm_ctrl
	import sgrpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sgrpm_stat_t stat,
	output sgrpm_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MAG,
		ST_LO,
		ST_HI,
		ST_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd      = '0;
		cmd.load = in_ready && in_valid;
		cmd.gain = (state_q == ST_GAIN);
		cmd.mag  = (state_q == ST_MAG);
		cmd.lo   = (state_q == ST_LO);
		cmd.hi   = (state_q == ST_HI);
		cmd.fin  = (state_q == ST_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_MAG;
				ST_MAG:  state_q <= ST_LO;
				ST_LO:   state_q <= ST_HI;
				ST_HI:   state_q <= ST_FIN;
				ST_FIN: begin
					// Hold the finished result until the output register frees up.
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/core/sgrpm_dp.sv
// Datapath of the stereo gain ramp and peak meter core: ramps, gain multipliers,
// peak holds, configuration registers and the output register.
// Depends on sgrpm_pkg and the channel interfaces in sgrpm_if.
module sgrpm_dp
	import sgrpm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sgrpm_in_if.sink    src,
	sgrpm_out_if.source dst,
	sgrpm_cfg_if.sink   cfg,
	input  sgrpm_cmd_t  cmd,
	output sgrpm_stat_t stat
);

	localparam int MAG_W  = SAMPLE_W + 1;        // magnitude of a sample; -32768 gives 32768
	localparam int PROD_W = 2 * LEVEL_W;          // full multiplier result
	localparam int A_W    = MAG_W + LEVEL_W - 2;  // magnitude times gain, at most 2^38
	localparam int SPLIT  = 20;                   // low part of the first product
	localparam int HI_W   = A_W - SPLIT;
	localparam int LO_P_W = SPLIT + LEVEL_W;
	localparam int HI_P_W = HI_W + LEVEL_W;
	localparam int SUM_W  = HI_P_W + SPLIT + 1;
	localparam int SHIFT  = 2 * (LEVEL_W - 1);

	// Configuration and ramp state.
	logic [LEVEL_W-1:0]  gate_step_q;
	logic [LEVEL_W-1:0]  volume_step_q;
	logic [LEVEL_W-1:0]  volume_target_q;
	logic [LEVEL_W-1:0]  gate_q;
	logic [LEVEL_W-1:0]  volume_q;
	logic [SAMPLE_W-1:0] peak_l_q;
	logic [SAMPLE_W-1:0] peak_r_q;
	logic                out_valid_q;

	// Per-transaction working registers.
	logic [MAG_W-1:0]    mag_l_q, mag_r_q;
	logic                neg_l_q, neg_r_q;
	logic                clear_q;
	logic [LEVEL_W-1:0]  p_q;
	logic [A_W-1:0]      a_l_q, a_r_q;
	logic [LO_P_W-1:0]   lo_l_q, lo_r_q;
	logic [HI_P_W-1:0]   hi_l_q, hi_r_q;

	// Output payload.
	logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
	logic        [SAMPLE_W-1:0] peak_left_q, peak_right_q;

	logic [LEVEL_W-1:0]  target;
	logic [LEVEL_W-1:0]  gate_nxt, volume_nxt;
	logic [MAG_W-1:0]    mag_l, mag_r;
	logic [LEVEL_W-1:0]  mul_a_l, mul_b_l, mul_a_r, mul_b_r;
	logic [PROD_W-1:0]   prod_l, prod_r;
	logic [SUM_W-1:0]    sum_l, sum_r;
	logic [SAMPLE_W-1:0] m_l, m_r;

	assign cfg.ready     = 1'b1;
	assign stat.out_free = !out_valid_q || dst.ready;

	// Ramps, evaluated against the incoming transaction.
	always_comb begin
		target = (volume_target_q > FULL_SCALE) ? FULL_SCALE : volume_target_q;

		if (src.fade_out) begin
			gate_nxt = (gate_q > gate_step_q) ? gate_q - gate_step_q : '0;
		end else if (gate_q < FULL_SCALE) begin
			gate_nxt = (FULL_SCALE - gate_q > gate_step_q) ? gate_q + gate_step_q
			                                                : FULL_SCALE;
		end else begin
			gate_nxt = gate_q;
		end

		if (volume_q < target) begin
			volume_nxt = (target - volume_q > volume_step_q) ? volume_q + volume_step_q
			                                                  : target;
		end else if (volume_q > target) begin
			volume_nxt = (volume_q - target > volume_step_q) ? volume_q - volume_step_q
			                                                  : target;
		end else begin
			volume_nxt = volume_q;
		end

		mag_l = src.left_in[SAMPLE_W-1]
			? MAG_W'(17'h10000 - {1'b0, src.left_in}) : {1'b0, src.left_in};
		mag_r = src.right_in[SAMPLE_W-1]
			? MAG_W'(17'h10000 - {1'b0, src.right_in}) : {1'b0, src.right_in};
	end

	// Two shared multipliers; the left one also forms gate times volume.
	always_comb begin
		mul_a_l = '0;
		mul_b_l = p_q;
		mul_a_r = '0;
		mul_b_r = p_q;
		if (cmd.gain) begin
			mul_a_l = gate_q;
			mul_b_l = volume_q;
		end else if (cmd.mag) begin
			mul_a_l = LEVEL_W'(mag_l_q);
			mul_a_r = LEVEL_W'(mag_r_q);
		end else if (cmd.lo) begin
			mul_a_l = LEVEL_W'(a_l_q[SPLIT-1:0]);
			mul_a_r = LEVEL_W'(a_r_q[SPLIT-1:0]);
		end else if (cmd.hi) begin
			mul_a_l = LEVEL_W'(a_l_q[A_W-1:SPLIT]);
			mul_a_r = LEVEL_W'(a_r_q[A_W-1:SPLIT]);
		end
		prod_l = PROD_W'(mul_a_l) * PROD_W'(mul_b_l);
		prod_r = PROD_W'(mul_a_r) * PROD_W'(mul_b_r);
	end

	// Recombine the partial products; the scaled magnitude never exceeds 2^15.
	always_comb begin
		sum_l = SUM_W'({hi_l_q, {SPLIT{1'b0}}}) + SUM_W'(lo_l_q);
		sum_r = SUM_W'({hi_r_q, {SPLIT{1'b0}}}) + SUM_W'(lo_r_q);
		m_l   = sum_l[SHIFT +: SAMPLE_W];
		m_r   = sum_r[SHIFT +: SAMPLE_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_step_q     <= GATE_STEP_RST;
			volume_step_q   <= VOLUME_STEP_RST;
			volume_target_q <= VOLUME_TARGET_RST;
			gate_q          <= '0;
			volume_q        <= FULL_SCALE;
			peak_l_q        <= '0;
			peak_r_q        <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_GATE_STEP:     gate_step_q     <= cfg.data;
					REG_VOLUME_STEP:   volume_step_q   <= cfg.data;
					REG_VOLUME_TARGET: volume_target_q <= cfg.data;
					default: ;
				endcase
			end

			if (cmd.load) begin
				gate_q   <= gate_nxt;
				volume_q <= volume_nxt;
				if (mag_l > MAG_W'(peak_l_q)) peak_l_q <= mag_l[SAMPLE_W-1:0];
				if (mag_r > MAG_W'(peak_r_q)) peak_r_q <= mag_r[SAMPLE_W-1:0];
			end else if (cmd.fin && stat.out_free && clear_q) begin
				peak_l_q <= '0;
				peak_r_q <= '0;
			end

			if (cmd.fin && stat.out_free) begin
				out_valid_q <= 1'b1;
			end else if (dst.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_l_q <= mag_l;
			mag_r_q <= mag_r;
			neg_l_q <= src.left_in[SAMPLE_W-1];
			neg_r_q <= src.right_in[SAMPLE_W-1];
			clear_q <= src.clear_peaks;
		end
		if (cmd.gain) p_q <= prod_l[LEVEL_W-1 +: LEVEL_W];
		if (cmd.mag) begin
			a_l_q <= prod_l[A_W-1:0];
			a_r_q <= prod_r[A_W-1:0];
		end
		if (cmd.lo) begin
			lo_l_q <= prod_l[LO_P_W-1:0];
			lo_r_q <= prod_r[LO_P_W-1:0];
		end
		if (cmd.hi) begin
			hi_l_q <= prod_l[HI_P_W-1:0];
			hi_r_q <= prod_r[HI_P_W-1:0];
		end
		if (cmd.fin && stat.out_free) begin
			left_out_q   <= neg_l_q ? -m_l : m_l;
			right_out_q  <= neg_r_q ? -m_r : m_r;
			peak_left_q  <= peak_l_q;
			peak_right_q <= peak_r_q;
		end
	end

	assign dst.valid      = out_valid_q;
	assign dst.left_out   = left_out_q;
	assign dst.right_out  = right_out_q;
	assign dst.peak_left  = peak_left_q;
	assign dst.peak_right = peak_right_q;

endmodule

FILE: test/stereo_gain_ramp_peak_meter_core_tb.sv
// Self-checking testbench for the stereo gain ramp and peak meter core.
// Depends on sgrpm_pkg, the channel interfaces in sgrpm_if and the core itself.
// A directed table runs first, then randomized phases checked by a local model.
module stereo_gain_ramp_peak_meter_core_tb
	import sgrpm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	// Index 3 decodes to no register; writes to it must leave the core unchanged.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_PCT     = 36;
	// Extra idle time after the last expected result has come back.
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 200;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left_out;
		logic signed [SAMPLE_W-1:0] right_out;
		logic        [SAMPLE_W-1:0] peak_left;
		logic        [SAMPLE_W-1:0] peak_right;
	} meter_result_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

	// One row of the directed table: either a register write or a sample pair.
	// Rows with typed set carry a result worked out by hand.
	typedef struct packed {
		row_kind_e                  kind;
		logic [CFG_IDX_W-1:0]       index;
		logic [LEVEL_W-1:0]         data;
		logic signed [SAMPLE_W-1:0] left_in;
		logic signed [SAMPLE_W-1:0] right_in;
		logic                       fade_out;
		logic                       clear_peaks;
		logic                       typed;
		meter_result_t              want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sgrpm_in_if  src_if ();
	sgrpm_out_if dst_if ();
	sgrpm_cfg_if cfg_if ();

	stereo_gain_ramp_peak_meter_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.dst    (dst_if),
		.cfg    (cfg_if)
	);

	// Local copy of the programmable registers, starting at their reset values.
	logic [LEVEL_W-1:0] gate_inc    = GATE_STEP_RST;
	logic [LEVEL_W-1:0] volume_inc  = VOLUME_STEP_RST;
	logic [LEVEL_W-1:0] volume_goal = VOLUME_TARGET_RST;

	// Local copy of the ramp and peak state: closed gate, full volume, no peaks.
	logic [LEVEL_W-1:0]  gate_now     = '0;
	logic [LEVEL_W-1:0]  volume_level = FULL_SCALE;
	logic [SAMPLE_W-1:0] hold_left    = '0;
	logic [SAMPLE_W-1:0] hold_right   = '0;

	meter_result_t pending_meter [$];
	stim_row_t     directed_rows [$];

	int  errors       = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	bit  hold_done    = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic stim_row_t write_row(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_WRITE;
		row.index = idx;
		row.data  = value;
		return row;
	endfunction

	function automatic stim_row_t sample_row(logic signed [SAMPLE_W-1:0] l, r, logic fade, clr);
		stim_row_t row;
		row             = '0;
		row.kind        = ROW_SAMPLE;
		row.left_in     = l;
		row.right_in    = r;
		row.fade_out    = fade;
		row.clear_peaks = clr;
		return row;
	endfunction

	function automatic stim_row_t known_row(logic signed [SAMPLE_W-1:0] l, r, logic fade, clr,
			logic signed [SAMPLE_W-1:0] lo, ro, logic [SAMPLE_W-1:0] pl, pr);
		stim_row_t row;
		row                 = sample_row(l, r, fade, clr);
		row.typed           = 1'b1;
		row.want.left_out   = lo;
		row.want.right_out  = ro;
		row.want.peak_left  = pl;
		row.want.peak_right = pr;
		return row;
	endfunction

	// Magnitude of a 16-bit sample; the most negative value gives 32768.
	function automatic logic [SAMPLE_W-1:0] magnitude(logic signed [SAMPLE_W-1:0] x);
		return x[15] ? 16'(17'h10000 - 17'(x[15:0])) : x[15:0];
	endfunction

	// Applies the squared gain, truncating the magnitude so the result rounds toward zero.
	function automatic logic signed [SAMPLE_W-1:0] scale_channel(logic signed [SAMPLE_W-1:0] x,
			logic [63:0] p);
		logic [63:0] scaled;
		scaled = (64'(magnitude(x)) * p * p) >> 46;
		return x[15] ? -scaled[15:0] : scaled[15:0];
	endfunction

	// Advances the gate and volume ramps by one sample, then scales and meters the pair.
	function automatic meter_result_t advance_meter(logic signed [SAMPLE_W-1:0] l, r,
			logic fade, clr);
		logic [LEVEL_W-1:0]  goal;
		logic [63:0]         p;
		logic [SAMPLE_W-1:0] mag_l;
		logic [SAMPLE_W-1:0] mag_r;
		meter_result_t       res;
		goal = (volume_goal > FULL_SCALE) ? FULL_SCALE : volume_goal;
		if (fade) begin
			gate_now = (gate_now > gate_inc) ? gate_now - gate_inc : '0;
		end else if (gate_now < FULL_SCALE) begin
			gate_now = (FULL_SCALE - gate_now > gate_inc) ? gate_now + gate_inc : FULL_SCALE;
		end
		if (volume_level < goal) begin
			volume_level = (goal - volume_level > volume_inc) ? volume_level + volume_inc : goal;
		end else if (volume_level > goal) begin
			volume_level = (volume_level - goal > volume_inc) ? volume_level - volume_inc : goal;
		end
		p = (64'(gate_now) * 64'(volume_level)) >> 23;
		res.left_out  = scale_channel(l, p);
		res.right_out = scale_channel(r, p);
		mag_l = magnitude(l);
		mag_r = magnitude(r);
		if (mag_l > hold_left) hold_left = mag_l;
		if (mag_r > hold_right) hold_right = mag_r;
		res.peak_left  = hold_left;
		res.peak_right = hold_right;
		// The holds are reported first and only then cleared.
		if (clr) begin
			hold_left  = '0;
			hold_right = '0;
		end
		return res;
	endfunction

	// Weighted toward the extremes and small values so that clipping-free edge cases recur.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(7))
			0: begin
				return -16'sd32768;
			end
			1: begin
				return 16'sd32767;
			end
			2: begin
				return $urandom_range(1) ? 16'sd1 : -16'sd1;
			end
			3: begin
				return 16'($urandom_range(511)) - 16'sd256;
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// Offers one sample pair, idling at random first. The valid stays high after the
	// transaction until the next falling edge, where the next call or a drain decides it.
	task automatic send_sample(logic signed [SAMPLE_W-1:0] l, r, logic fade, clr,
			logic typed, meter_result_t want);
		meter_result_t res;
		bit            steady;
		steady = (samples_sent >= 600 && samples_sent < 850);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			src_if.valid <= 1'b0;
			@(negedge clk);
		end
		src_if.valid       <= 1'b1;
		src_if.left_in     <= l;
		src_if.right_in    <= r;
		src_if.fade_out    <= fade;
		src_if.clear_peaks <= clr;
		do @(posedge clk); while (!src_if.ready);
		// The model always advances, even where the table supplies the result by hand.
		res = advance_meter(l, r, fade, clr);
		pending_meter.push_back(typed ? want : res);
		samples_sent++;
	endtask

	// Withdraws the input and lets the core run dry before anything else happens.
	task automatic quiesce();
		@(negedge clk);
		src_if.valid <= 1'b0;
		while (pending_meter.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register writes only ever happen with the core idle.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] value);
		quiesce();
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_GATE_STEP: begin
				gate_inc = value;
			end
			REG_VOLUME_STEP: begin
				volume_inc = value;
			end
			REG_VOLUME_TARGET: begin
				volume_goal = value;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Output side: ready toggles at random on each falling edge. Once, after a few
	// hundred results, ready is held low for a long stretch so that the core backs
	// up and stalls its input while the sender keeps offering transactions. A later
	// window keeps ready high throughout.
	initial begin
		dst_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && results_seen >= 400) begin
				hold_done = 1;
				dst_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			dst_if.ready <= (results_seen >= 900 && results_seen < 1150) ||
				($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Every output transaction is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		meter_result_t want;
		if (arst_n && dst_if.valid && dst_if.ready) begin
			results_seen++;
			if (pending_meter.size() == 0) begin
				$error("output transaction with no expected result: left_out %0d right_out %0d",
					$signed(dst_if.left_out), $signed(dst_if.right_out));
				errors++;
			end else begin
				want = pending_meter.pop_front();
				if (dst_if.left_out !== want.left_out) begin
					$error("left_out: expected %0d, got %0d",
						$signed(want.left_out), $signed(dst_if.left_out));
					errors++;
				end
				if (dst_if.right_out !== want.right_out) begin
					$error("right_out: expected %0d, got %0d",
						$signed(want.right_out), $signed(dst_if.right_out));
					errors++;
				end
				if (dst_if.peak_left !== want.peak_left) begin
					$error("peak_left: expected %0d, got %0d", want.peak_left, dst_if.peak_left);
					errors++;
				end
				if (dst_if.peak_right !== want.peak_right) begin
					$error("peak_right: expected %0d, got %0d", want.peak_right, dst_if.peak_right);
					errors++;
				end
			end
		end
	end

	// Main sequence: reset, directed table, randomized phases, drain and verdict.
	initial begin
		stim_row_t          row;
		meter_result_t      blank;
		logic [LEVEL_W-1:0] value;
		logic               fade_now;
		int                 run_left;
		int                 phase_left;
		int                 random_sent;
		bit                 paused;

		arst_n             = 1'b0;
		src_if.valid       = 1'b0;
		src_if.left_in     = '0;
		src_if.right_in    = '0;
		src_if.fade_out    = 1'b0;
		src_if.clear_peaks = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_GATE_STEP;
		cfg_if.data        = '0;
		blank              = '0;
		fade_now           = 1'b0;
		run_left           = 0;
		random_sent        = 0;
		paused             = 0;

		// Straight out of reset the gate is closed, so fading keeps every output at zero
		// while the meters still see the full input swing, the most negative one included.
		directed_rows.push_back(known_row(16'sd32767, -16'sd32768, 1, 0, 0, 0, 32767, 32768));
		// A clear still reports the held peaks, then drops them.
		directed_rows.push_back(known_row(-16'sd1, 16'sd1, 1, 1, 0, 0, 32767, 32768));
		directed_rows.push_back(known_row(16'sd0, 16'sd0, 1, 0, 0, 0, 0, 0));
		// A full-scale gate step opens the gate in one sample: unity gain, exact pass-through.
		directed_rows.push_back(write_row(REG_GATE_STEP, FULL_SCALE));
		directed_rows.push_back(known_row(-16'sd32768, 16'sd32767, 0, 1,
			-16'sd32768, 16'sd32767, 32768, 32767));
		directed_rows.push_back(known_row(16'sd12345, -16'sd23456, 0, 0,
			16'sd12345, -16'sd23456, 12345, 23456));
		directed_rows.push_back(known_row(16'sd1, -16'sd1, 1, 1, 0, 0, 12345, 23456));
		// A zero gate step freezes the closed gate.
		directed_rows.push_back(write_row(REG_GATE_STEP, '0));
		directed_rows.push_back(sample_row(16'sd20000, -16'sd20000, 0, 0));
		// A gate step beyond full scale saturates at unity.
		directed_rows.push_back(write_row(REG_GATE_STEP, 24'hFFFFFF));
		directed_rows.push_back(sample_row(-16'sd32768, -16'sd32768, 0, 0));
		// Volume drops straight to a zero target, then climbs toward an over-range
		// target that behaves as full scale.
		directed_rows.push_back(write_row(REG_VOLUME_TARGET, '0));
		directed_rows.push_back(write_row(REG_VOLUME_STEP, 24'hFFFFFF));
		directed_rows.push_back(sample_row(16'sd32767, 16'sd32767, 0, 1));
		directed_rows.push_back(write_row(REG_VOLUME_TARGET, 24'hFFFFFF));
		directed_rows.push_back(write_row(REG_VOLUME_STEP, 24'd3000000));
		directed_rows.push_back(sample_row(16'sd30000, -16'sd30000, 0, 0));
		directed_rows.push_back(sample_row(-16'sd32768, 16'sd32767, 0, 0));
		directed_rows.push_back(sample_row(16'sd32767, -16'sd32768, 0, 0));
		// A zero volume step freezes the volume even with a new target set.
		directed_rows.push_back(write_row(REG_VOLUME_STEP, '0));
		directed_rows.push_back(write_row(REG_VOLUME_TARGET, 24'd4194304));
		directed_rows.push_back(sample_row(-16'sd32768, 16'sd30000, 0, 0));
		// A write to the unused index must not disturb anything.
		directed_rows.push_back(write_row(REG_SPARE, 24'h5A5A5A));
		directed_rows.push_back(sample_row(16'sd32767, -16'sd1, 0, 0));
		directed_rows.push_back(write_row(REG_VOLUME_STEP, FULL_SCALE));
		directed_rows.push_back(sample_row(-16'sd32768, 16'sd32767, 0, 0));
		directed_rows.push_back(write_row(REG_GATE_STEP, 24'd1));
		directed_rows.push_back(sample_row(16'sd32767, -16'sd32767, 1, 1));
		directed_rows.push_back(write_row(REG_GATE_STEP, GATE_STEP_RST));
		directed_rows.push_back(write_row(REG_VOLUME_STEP, VOLUME_STEP_RST));
		directed_rows.push_back(write_row(REG_VOLUME_TARGET, VOLUME_TARGET_RST));
		directed_rows.push_back(sample_row(-16'sd12000, 16'sd9000, 1, 0));
		directed_rows.push_back(sample_row(16'sd4096, -16'sd4096, 0, 1));

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				write_register(row.index, row.data);
			end else begin
				send_sample(row.left_in, row.right_in, row.fade_out, row.clear_peaks,
					row.typed, row.want);
			end
		end

		// Randomized phases. Each phase programs all three registers with a mix of
		// extremes and ordinary values, then plays longer fade runs that alternate in
		// direction, broken up now and then by short noisy runs.
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(6))
				0: value = '0;
				1: value = 24'd1;
				2: value = GATE_STEP_RST;
				3: value = FULL_SCALE;
				4: value = 24'hFFFFFF;
				default: value = 24'($urandom_range(400000, 1));
			endcase
			write_register(REG_GATE_STEP, value);
			case ($urandom_range(6))
				0: value = '0;
				1: value = 24'd1;
				2: value = VOLUME_STEP_RST;
				3: value = FULL_SCALE;
				4: value = 24'hFFFFFF;
				default: value = 24'($urandom_range(300000));
			endcase
			write_register(REG_VOLUME_STEP, value);
			case ($urandom_range(5))
				0: value = '0;
				1: value = FULL_SCALE;
				2: value = 24'hFFFFFF;
				3: value = 24'($urandom);
				default: value = 24'($urandom_range(FULL_SCALE));
			endcase
			write_register(REG_VOLUME_TARGET, value);
			if ($urandom_range(3) == 0) begin
				write_register(REG_SPARE, 24'($urandom));
			end

			phase_left = $urandom_range(220, 60);
			while (phase_left > 0 && random_sent < RANDOM_ITEMS) begin
				if (run_left == 0) begin
					if ($urandom_range(3) == 0) begin
						fade_now = 1'($urandom_range(1));
						run_left = $urandom_range(3, 1);
					end else begin
						fade_now = !fade_now;
						run_left = $urandom_range(90, 10);
					end
				end
				run_left--;
				send_sample(pick_sample(), pick_sample(), fade_now, $urandom_range(15) == 0,
					1'b0, blank);
				random_sent++;
				phase_left--;
				// Once mid-run, stop offering until every pending result has come back.
				if (!paused && random_sent == 700) begin
					paused = 1;
					quiesce();
				end
			end
		end

		quiesce();
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/sgrpm_pkg.sv
rtl/core/sgrpm_if.sv
rtl/core/sgrpm_ctrl.sv
rtl/core/sgrpm_dp.sv
rtl/core/stereo_gain_ramp_peak_meter_core.sv
test/stereo_gain_ramp_peak_meter_core_tb.sv
